>>> hdl/trigger_abs_time_tagger_top_defines.svh
// ----------------------------------------------------------------------------
// Trigger absolute time tagger: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIGGER_ABS_TIME_TAGGER_TOP_DEFINES_SVH
`define TRIGGER_ABS_TIME_TAGGER_TOP_DEFINES_SVH

// same-cycle implication
`define TAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/tat_pkg.sv
// ----------------------------------------------------------------------------
// Trigger absolute time tagger: package
// Types, constants and helpers shared by the tagger modules.
// ----------------------------------------------------------------------------
package tat_pkg;

    localparam int unsigned DIV_W    = 53;
    localparam int unsigned DEN_W    = 27;
    localparam int unsigned TQ_W     = 56;

    typedef logic signed [TQ_W-1:0] tq_t;

    localparam logic [19:0]     WEEK_SEC   = 20'd604800;
    localparam tq_t             WEEK_LIMIT = tq_t'(WEEK_SEC) <<< 32;
    localparam logic [12:0]     ROLL_EDGE  = 13'd629;
    localparam logic [12:0]     ROLL_FIRST = 13'd1024;
    localparam logic [12:0]     ROLL_ADD1  = 13'd1024;
    localparam logic [12:0]     ROLL_ADD2  = 13'd2048;
    localparam logic [31:0]     CNT_MAX    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REG_OFF_LIM    = 2'd0,
        REG_DIFF_LIM   = 2'd1,
        REG_SPREAD_LIM = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        OUT_OK        = 3'd0,
        OUT_BEF_FAIL  = 3'd1,
        OUT_AFT_FAIL  = 3'd2,
        OUT_BOTH_FAIL = 3'd3,
        OUT_TOO_DIFF  = 3'd4,
        OUT_BEF_LAST  = 3'd5
    } outcome_t;

    typedef enum logic [4:0] {
        S_IDLE, S_MF, S_MB, S_MA, S_CYC, S_CYCW, S_GAP, S_SDW, S_DD, S_ADJ,
        S_EST, S_RNG, S_CMB, S_SEL, S_WK, S_WKW, S_DONE
    } state_t;

    typedef struct packed {
        logic [39:0] off_lim;
        logic [39:0] diff_lim;
        logic [39:0] spread_lim;
    } tat_cfg_t;

    typedef struct packed {
        logic [3:0]  status_bits;
        logic [26:0] tick_rate;
        logic [31:0] after_counter;
        logic [39:0] after_second;
        logic [11:0] after_week;
        logic [31:0] before_counter;
        logic [39:0] before_second;
        logic [11:0] before_week;
        logic [31:0] trigger_counter;
        logic [39:0] frame_second;
        logic [11:0] frame_week;
    } tat_item_t;

    typedef struct packed {
        logic [31:0]        valid_total;
        logic [31:0]        error_total;
        outcome_t           outcome;
        logic               abs_valid;
        logic signed [40:0] abs_second;
        logic signed [12:0] abs_week;
    } tat_res_t;

    function automatic tq_t to_q20(input logic [11:0] w, input logic [39:0] s);
        logic [31:0] p;
        p = 32'(w) * 32'(WEEK_SEC);
        return (tq_t'(p) <<< 20) + tq_t'(s);
    endfunction

endpackage

>>> hdl/tat_div.sv
// ----------------------------------------------------------------------------
// Trigger absolute time tagger: serial divider
// Restoring divider, one quotient bit per cycle, 53-bit dividend.
// ----------------------------------------------------------------------------
module tat_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tat_pkg::DIV_W-1:0]      dividend,
    input  logic [tat_pkg::DEN_W-1:0]      divisor,
    output logic                           done,
    output logic [tat_pkg::DIV_W-1:0]      quotient,
    output logic [tat_pkg::DEN_W-1:0]      remainder
);
    import tat_pkg::*;

    logic [DIV_W-1:0] dq_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [5:0]       cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_new;

    always_comb
    begin
        rem_sh  = {rem_reg, dq_reg[DIV_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_new = ge ? rem_sh - {1'b0, den_reg} : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 6'(DIV_W - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (run_reg)
        begin
            dq_reg  <= {dq_reg[DIV_W-2:0], ge};
            rem_reg <= rem_new[DEN_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/tat_core.sv
// ----------------------------------------------------------------------------
// Trigger absolute time tagger: sequencer and datapath
// Steps a trigger through the before and, if present, after reference
// estimates, selection, week split, saturating counters; one serial divider.
// ----------------------------------------------------------------------------
module tat_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  tat_pkg::tat_item_t item,
    input  tat_pkg::tat_cfg_t  cfg,
    input  logic               res_ready,
    output logic               idle,
    output logic               res_load,
    output tat_pkg::tat_res_t  res
);
    import tat_pkg::*;

    state_t    state_reg, state_next;
    tat_item_t item_reg;
    tq_t       tf_reg, tb_reg, ta_reg;
    tq_t       cycle_reg, gap_reg, sd_reg, dd_reg, adj_reg, e_reg, t_reg;
    tq_t       eb_reg, ea_reg, dif_reg, sum_reg, sel_t_reg;
    logic      off_fail_reg, neg_reg, inband_reg, chk_reg;
    logic      okb_reg, oka_reg, has_reg, ref_sel_reg;
    logic signed [12:0] wk_reg;
    logic signed [40:0] sec_reg;
    logic      valid_reg;
    outcome_t  outc_reg;
    logic [31:0] err_reg, val_reg;

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DEN_W-1:0]  div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_q;
    logic [DEN_W-1:0]  div_r;

    logic [DEN_W-1:0]  tps;
    tq_t               tref, md, eabs, difabs, t_chk;
    logic [31:0]       cnt_ref;
    logic [32:0]       cdiff;
    logic [31:0]       cmag;
    logic              pos, ng, rng_ok, bv, av, present;
    logic [12:0]       wq;

    tat_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        tps     = (item_reg.tick_rate == '0) ? DEN_W'(1) : item_reg.tick_rate;
        tref    = ref_sel_reg ? ta_reg : tb_reg;
        cnt_ref = ref_sel_reg ? item_reg.after_counter : item_reg.before_counter;
        cdiff   = {1'b0, item_reg.trigger_counter} - {1'b0, cnt_ref};
        cmag    = cdiff[32] ? 32'(-cdiff) : cdiff[31:0];
        md      = tq_t'(cfg.diff_lim);
        pos     = dd_reg > md;
        ng      = dd_reg < -md;
        eabs    = e_reg[TQ_W-1] ? -e_reg : e_reg;
        difabs  = dif_reg[TQ_W-1] ? -dif_reg : dif_reg;
        t_chk   = tref + sd_reg + adj_reg;
        rng_ok  = chk_reg && !off_fail_reg && !t_reg[TQ_W-1] && (t_reg < WEEK_LIMIT);
        bv      = item_reg.status_bits[1];
        av      = item_reg.status_bits[2];
        present = item_reg.status_bits[3];
        wq      = div_q[12:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = item.status_bits[0] ? S_DONE : S_MF;
            S_MF:   state_next = S_MB;
            S_MB:   state_next = S_MA;
            S_MA:   state_next = S_CYC;
            S_CYC:  state_next = S_CYCW;
            S_CYCW: if (div_done) state_next = S_GAP;
            S_GAP:  state_next = S_SDW;
            S_SDW:  if (div_done) state_next = S_DD;
            S_DD:   state_next = S_ADJ;
            S_ADJ:  state_next = S_EST;
            S_EST:  state_next = S_RNG;
            S_RNG:  state_next = (!ref_sel_reg && present) ? S_GAP : S_CMB;
            S_CMB:  state_next = S_SEL;
            S_SEL:  state_next = S_WK;
            S_WK:   state_next = has_reg ? S_WKW : S_DONE;
            S_WKW:  if (div_done) state_next = S_DONE;
            S_DONE: if (res_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = tps;
        res_load     = 1'b0;
        unique case (state_reg)
            S_CYC:
            begin
                div_start    = 1'b1;
                div_dividend = (DIV_W'(1) << 52) + DIV_W'(tps >> 1);
            end
            S_GAP:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({cmag, 20'b0}) + DIV_W'(tps >> 1);
            end
            S_WK:
            begin
                div_start    = has_reg;
                div_dividend = DIV_W'(t_reg[52:20]);
                div_divisor  = DEN_W'(WEEK_SEC);
            end
            S_DONE: res_load = res_ready;
            default: div_start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            err_reg   <= '0;
            val_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_WK)
            begin
                if (outc_reg != OUT_OK && err_reg != CNT_MAX)
                    err_reg <= err_reg + 32'd1;
                if (has_reg && valid_reg && val_reg != CNT_MAX)
                    val_reg <= val_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                item_reg  <= item;
                wk_reg    <= '1;
                sec_reg   <= '1;
                valid_reg <= 1'b0;
                outc_reg  <= OUT_OK;
                has_reg   <= 1'b0;
            end
            S_MF: tf_reg <= to_q20(item_reg.frame_week, item_reg.frame_second);
            S_MB: tb_reg <= to_q20(item_reg.before_week, item_reg.before_second);
            S_MA: ta_reg <= to_q20(item_reg.after_week, item_reg.after_second);
            S_CYC: ref_sel_reg <= 1'b0;
            S_CYCW: if (div_done) cycle_reg <= tq_t'(div_q);
            S_GAP:
            begin
                gap_reg      <= tf_reg - tref;
                off_fail_reg <= (tf_reg - tref) > tq_t'(cfg.off_lim);
                neg_reg      <= cdiff[32];
            end
            S_SDW: if (div_done) sd_reg <= neg_reg ? -tq_t'(div_q) : tq_t'(div_q);
            S_DD: dd_reg <= gap_reg - sd_reg;
            S_ADJ:
            begin
                adj_reg    <= pos ? cycle_reg : (ng ? -cycle_reg : '0);
                e_reg      <= dd_reg - (pos ? cycle_reg : (ng ? -cycle_reg : '0));
                inband_reg <= !pos && !ng;
            end
            S_EST:
            begin
                chk_reg <= inband_reg || (eabs < md);
                t_reg   <= t_chk;
            end
            S_RNG:
            begin
                if (!ref_sel_reg)
                begin
                    eb_reg      <= t_reg;
                    okb_reg     <= rng_ok;
                    ref_sel_reg <= 1'b1;
                end
                else
                begin
                    ea_reg  <= t_reg;
                    oka_reg <= rng_ok;
                end
            end
            S_CMB:
            begin
                dif_reg <= ea_reg - eb_reg;
                sum_reg <= ea_reg + eb_reg;
                if (present)
                begin
                    priority if (!okb_reg && !oka_reg)
                    begin
                        outc_reg <= OUT_BOTH_FAIL; valid_reg <= bv && av;
                    end
                    else if (!okb_reg)
                    begin
                        outc_reg <= OUT_BEF_FAIL; valid_reg <= av;
                        has_reg <= 1'b1; sel_t_reg <= ea_reg;
                    end
                    else if (!oka_reg)
                    begin
                        outc_reg <= OUT_AFT_FAIL; valid_reg <= bv;
                        has_reg <= 1'b1; sel_t_reg <= eb_reg;
                    end
                    else
                    begin
                        outc_reg <= OUT_OK; valid_reg <= bv && av; has_reg <= 1'b1;
                    end
                end
                else
                begin
                    valid_reg <= bv;
                    if (okb_reg)
                    begin
                        has_reg <= 1'b1; sel_t_reg <= eb_reg;
                    end
                    else
                    begin
                        outc_reg <= OUT_BEF_LAST;
                    end
                end
            end
            S_SEL:
            begin
                if (present && okb_reg && oka_reg)
                begin
                    if (difabs > tq_t'(cfg.spread_lim))
                    begin
                        outc_reg <= OUT_TOO_DIFF;
                        has_reg  <= 1'b0;
                    end
                    else
                    begin
                        t_reg <= sum_reg >>> 1;
                    end
                end
                else
                begin
                    t_reg <= sel_t_reg;
                end
            end
            S_WKW:
            begin
                if (div_done)
                begin
                    if (wq != '0 && wq < ROLL_FIRST)
                        wk_reg <= $signed(wq + ((wq > ROLL_EDGE) ? ROLL_ADD1 : ROLL_ADD2));
                    else
                        wk_reg <= $signed(wq);
                    sec_reg <= $signed({1'b0, div_r[19:0], t_reg[19:0]});
                end
            end
            default: item_reg <= item_reg;
        endcase
    end

    assign idle = (state_reg == S_IDLE);

    always_comb
    begin
        res.abs_week    = wk_reg;
        res.abs_second  = sec_reg;
        res.abs_valid   = valid_reg;
        res.outcome     = outc_reg;
        res.error_total = err_reg;
        res.valid_total = val_reg;
    end

endmodule

>>> hdl/trigger_abs_time_tagger_top.sv
// ----------------------------------------------------------------------------
// Trigger absolute time tagger: top level
// Usage:
//  Input stream s_*: one transaction per trigger (frame time, tick counter,
//  before and after sync references, tick rate); status bits ride on s_tuser.
//  Output stream m_*: one transaction per input with the absolute GPS time,
//  outcome code and the running error and valid counts.
//  Config port: cfg_we/cfg_addr/cfg_wdata write the three Q20 tolerances,
//  0 offset limit, 1 diff limit, 2 spread limit; write only while idle.
//  A trigger with a bad status bit goes straight to the result; otherwise the
//  53-step serial divider is used for the cycle length, each counter gap and
//  the week split (the last only when a time results). One trigger is in
//  work at a time; the next one is accepted in the cycle after the result
//  is loaded into the output register.
//  Reset clears the tolerances, both counters and all handshake state.
//  If m_tready stays low the finished result is held in the output register;
//  the next trigger is worked and then waits in its final state, and
//  s_tready stays low until the sequencer is idle again.
// ----------------------------------------------------------------------------
`include "trigger_abs_time_tagger_top_defines.svh"

module trigger_abs_time_tagger_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // frame_week, frame_second, trigger_counter, before_week, before_second,
    // before_counter, after_week, after_second, after_counter, tick_rate
    input  logic [279:0] s_tdata,
    // status_bits
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // abs_week, abs_second, abs_valid, outcome, error_total, valid_total
    output logic [127:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [39:0]  cfg_wdata
);
    import tat_pkg::*;

    tat_cfg_t  cfg_reg;
    tat_item_t item;
    tat_res_t  res;
    logic      core_idle, res_load, res_ready, start;
    logic [127:0] m_tdata_reg;
    logic      m_tvalid_reg;

    always_comb
    begin
        item.frame_week       = s_tdata[11:0];
        item.frame_second     = s_tdata[51:12];
        item.trigger_counter  = s_tdata[83:52];
        item.before_week      = s_tdata[95:84];
        item.before_second    = s_tdata[135:96];
        item.before_counter   = s_tdata[167:136];
        item.after_week       = s_tdata[179:168];
        item.after_second     = s_tdata[219:180];
        item.after_counter    = s_tdata[251:220];
        item.tick_rate        = s_tdata[278:252];
        item.status_bits      = s_tuser;
    end

    assign s_tready  = core_idle;
    assign start     = s_tvalid && core_idle;
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_OFF_LIM:    cfg_reg.off_lim    <= cfg_wdata;
                REG_DIFF_LIM:   cfg_reg.diff_lim   <= cfg_wdata;
                REG_SPREAD_LIM: cfg_reg.spread_lim <= cfg_wdata;
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    tat_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cfg       (cfg_reg),
        .res_ready (res_ready),
        .idle      (core_idle),
        .res_load  (res_load),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (res_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            m_tdata_reg <= 128'(res);
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `TAT_ASSERT_NEXT(a_busy_after_start, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `TAT_ASSERT_NOW(a_no_overwrite, res_load, !m_tvalid || m_tready, "result overwritten")
    `TAT_ASSERT_NOW(a_outcome_range, m_tvalid, m_tdata[57:55] <= 3'd5, "bad outcome code")

endmodule
